### src/sfi_pkg.sv
// ----------------------------------------------------------------------------
// sfi_pkg
// Shared constants and types for the simplest fraction in interval unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sfi_pkg;

    // Default operand width (numerator bits)
    localparam int DEF_WIDTH = 32;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CMP_DA,
        ST_CMP_DC,
        ST_CMP_EV,
        ST_SOL_DA,
        ST_SOL_DC,
        ST_SOL_EV,
        ST_MAC_P,
        ST_MAC_Q,
        ST_FIN_P,
        ST_FIN_Q,
        ST_DONE
    } state_t;

    // Handshake between sequencer and an iterative unit
    typedef struct packed {
        logic start;
    } unit_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_rsp_t;

endpackage

`default_nettype wire

### src/sfi_div.sv
// ----------------------------------------------------------------------------
// sfi_div
// Restoring divider, one quotient bit per cycle, quotient and remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module sfi_div #(
    parameter int WIDTH = sfi_pkg::DEF_WIDTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sfi_pkg::unit_req_t req,
    output sfi_pkg::unit_rsp_t      rsp,
    input  wire logic [WIDTH-1:0]   dividend,
    input  wire logic [WIDTH-1:0]   divisor,
    output logic [WIDTH-1:0]        quotient,
    output logic [WIDTH-1:0]        remainder
);

    localparam int CW = $clog2(WIDTH);

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] quo_reg;
    logic [WIDTH-1:0] dvs_reg;
    logic [WIDTH:0]   trial;
    logic             fits;

    // Shift in the next dividend bit and try the subtraction
    assign trial = {rem_reg, quo_reg[WIDTH-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(WIDTH - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= WIDTH'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_reg <= trial[WIDTH-1:0];
            end
            quo_reg <= {quo_reg[WIDTH-2:0], fits};
        end
    end

    assign rsp.busy  = busy_reg;
    assign rsp.done  = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

### src/sfi_mac.sv
// ----------------------------------------------------------------------------
// sfi_mac
// Shift-add multiply-accumulate, m * x + y, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sfi_mac #(
    parameter int WIDTH = sfi_pkg::DEF_WIDTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sfi_pkg::unit_req_t req,
    output sfi_pkg::unit_rsp_t      rsp,
    input  wire logic [WIDTH-1:0]   mul_m,
    input  wire logic [WIDTH-1:0]   mul_x,
    input  wire logic [WIDTH-1:0]   add_y,
    output logic [WIDTH-1:0]        result
);

    localparam int CW = $clog2(WIDTH);

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] addend_reg;
    logic [WIDTH-1:0] mult_reg;

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(WIDTH - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Accumulate shifted partial products
    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            acc_reg    <= add_y;
            addend_reg <= mul_x;
            mult_reg   <= mul_m;
        end
        else if (busy_reg)
        begin
            if (mult_reg[0])
            begin
                acc_reg <= acc_reg + addend_reg;
            end
            addend_reg <= {addend_reg[WIDTH-2:0], 1'b0};
            mult_reg   <= {1'b0, mult_reg[WIDTH-1:1]};
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign result   = acc_reg;

endmodule

`default_nettype wire

### src/simplest_fraction_in_interval_unit.sv
// Ordering check: each step runs two divisions on the shared divider. Each
// continued-fraction step: two divisions on the shared divider and two shift-add
// updates; the last step likewise, forming the convergent. Zero-denominator,
// zero-straddling or sign-rejected requests go straight to the result state on
// acceptance. One request at a time: in_stall high until done.
// Reset (rst_n, asynchronous, active low) clears sequencer and output valid.
// ----------------------------------------------------------------------------
// simplest_fraction_in_interval_unit
// Finds the fraction of smallest denominator in a closed interval using
// continued-fraction steps on a shared divider and multiply-accumulate unit.
// ----------------------------------------------------------------------------
`default_nettype none

module simplest_fraction_in_interval_unit #(
    parameter int WIDTH = sfi_pkg::DEF_WIDTH
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic signed [WIDTH-1:0] lower_num,
    input  wire logic [WIDTH-2:0]        lower_den,
    input  wire logic signed [WIDTH-1:0] upper_num,
    input  wire logic [WIDTH-2:0]        upper_den,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic signed [WIDTH-1:0]      result_num,
    output logic [WIDTH-2:0]             result_den,
    output logic                         input_error
);

    sfi_pkg::state_t state_reg, state_next;

    logic [WIDTH-1:0] a_reg, b_reg, c_reg, d_reg;
    logic [WIDTH-1:0] oa_reg, ob_reg, oc_reg, od_reg;
    logic [WIDTH-1:0] qa_reg, ra_reg;
    logic [WIDTH-1:0] p0_reg, p1_reg, q0_reg, q1_reg;
    logic [WIDTH-1:0] k_reg, t_reg, rn_reg, rd_reg;
    logic             sneg_reg, neg_reg, err_reg, issued_reg;
    logic             out_valid_reg;
    logic [WIDTH-1:0] out_num_reg;
    logic [WIDTH-2:0] out_den_reg;
    logic             out_err_reg;

    sfi_pkg::unit_req_t div_req, mac_req;
    sfi_pkg::unit_rsp_t div_rsp, mac_rsp;
    logic [WIDTH-1:0]   div_n, div_d, div_q, div_r;
    logic [WIDTH-1:0]   mac_m, mac_x, mac_y, mac_res;

    logic             accept;
    logic             lo_neg, hi_neg, lo_zero, hi_zero, lo_pos, hi_pos;
    logic [WIDTH-1:0] lo_mag, hi_mag, lo_den_w, hi_den_w;
    logic             den_bad, order_bad, go_cmp;
    logic             qa_lt, qa_ne, ra_z, rc_z, k_fits;
    logic [WIDTH-1:0] k_new;
    logic             deliver;

    assign accept  = in_valid && !in_stall;
    assign deliver = (state_reg == sfi_pkg::ST_DONE) && (!out_valid_reg || !out_stall);

    // Decode request signs and magnitudes
    assign lo_neg   = lower_num[WIDTH-1];
    assign hi_neg   = upper_num[WIDTH-1];
    assign lo_mag   = lo_neg ? WIDTH'(-lower_num) : lower_num;
    assign hi_mag   = hi_neg ? WIDTH'(-upper_num) : upper_num;
    assign lo_zero  = (lower_num == '0);
    assign hi_zero  = (upper_num == '0);
    assign lo_pos   = !lo_zero && !lo_neg;
    assign hi_pos   = !hi_zero && !hi_neg;
    assign lo_den_w = {1'b0, lower_den};
    assign hi_den_w = {1'b0, upper_den};
    assign den_bad  = (lower_den == '0) || (upper_den == '0);
    assign order_bad = (lo_pos && !hi_pos) || (lo_zero && hi_neg);
    assign go_cmp   = (lo_pos && hi_pos) || (lo_neg && hi_neg);

    // Step evaluation from the two divisions
    assign qa_ne  = (qa_reg != div_q);
    assign qa_lt  = (qa_reg < div_q);
    assign ra_z   = (ra_reg == '0);
    assign rc_z   = (div_r == '0);
    assign k_new  = qa_reg + WIDTH'(!ra_z);
    assign k_fits = (k_new <= div_q);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sfi_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (!den_bad && !order_bad && go_cmp)
                        state_next = sfi_pkg::ST_CMP_DA;
                    else
                        state_next = sfi_pkg::ST_DONE;
                end
            end
            sfi_pkg::ST_CMP_DA: if (div_rsp.done) state_next = sfi_pkg::ST_CMP_DC;
            sfi_pkg::ST_CMP_DC: if (div_rsp.done) state_next = sfi_pkg::ST_CMP_EV;
            sfi_pkg::ST_CMP_EV:
            begin
                if (qa_ne || ra_z || rc_z)
                begin
                    if (qa_ne ? (qa_lt == sneg_reg) : (ra_z && rc_z ? 1'b0
                                                     : (ra_z ? sneg_reg : !sneg_reg)))
                        state_next = sfi_pkg::ST_DONE;
                    else
                        state_next = sfi_pkg::ST_SOL_DA;
                end
                else
                begin
                    state_next = sfi_pkg::ST_CMP_DA;
                end
            end
            sfi_pkg::ST_SOL_DA: if (div_rsp.done) state_next = sfi_pkg::ST_SOL_DC;
            sfi_pkg::ST_SOL_DC: if (div_rsp.done) state_next = sfi_pkg::ST_SOL_EV;
            sfi_pkg::ST_SOL_EV:
            begin
                if (k_fits || rc_z || ra_z)
                    state_next = sfi_pkg::ST_FIN_P;
                else
                    state_next = sfi_pkg::ST_MAC_P;
            end
            sfi_pkg::ST_MAC_P: if (mac_rsp.done) state_next = sfi_pkg::ST_MAC_Q;
            sfi_pkg::ST_MAC_Q: if (mac_rsp.done) state_next = sfi_pkg::ST_SOL_DA;
            sfi_pkg::ST_FIN_P: if (mac_rsp.done) state_next = sfi_pkg::ST_FIN_Q;
            sfi_pkg::ST_FIN_Q: if (mac_rsp.done) state_next = sfi_pkg::ST_DONE;
            sfi_pkg::ST_DONE:  if (deliver) state_next = sfi_pkg::ST_IDLE;
            default:           state_next = sfi_pkg::ST_IDLE;
        endcase
    end

    // Unit requests and operand selection
    always_comb
    begin
        div_req.start = 1'b0;
        mac_req.start = 1'b0;
        div_n = a_reg;
        div_d = b_reg;
        mac_m = t_reg;
        mac_x = p1_reg;
        mac_y = p0_reg;
        unique case (state_reg) inside
            sfi_pkg::ST_CMP_DA, sfi_pkg::ST_SOL_DA:
            begin
                div_req.start = !issued_reg;
            end
            sfi_pkg::ST_CMP_DC, sfi_pkg::ST_SOL_DC:
            begin
                div_req.start = !issued_reg;
                div_n = c_reg;
                div_d = d_reg;
            end
            sfi_pkg::ST_MAC_P:
            begin
                mac_req.start = !issued_reg;
            end
            sfi_pkg::ST_MAC_Q:
            begin
                mac_req.start = !issued_reg;
                mac_x = q1_reg;
                mac_y = q0_reg;
            end
            sfi_pkg::ST_FIN_P:
            begin
                mac_req.start = !issued_reg;
                mac_m = k_reg;
            end
            sfi_pkg::ST_FIN_Q:
            begin
                mac_req.start = !issued_reg;
                mac_m = k_reg;
                mac_x = q1_reg;
                mac_y = q0_reg;
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sfi_pkg::ST_IDLE;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (div_rsp.done || mac_rsp.done)
                issued_reg <= 1'b0;
            else if (div_req.start || mac_req.start)
                issued_reg <= 1'b1;
            if (deliver)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg) inside
            sfi_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    err_reg  <= den_bad || order_bad;
                    neg_reg  <= !den_bad && lo_neg && hi_neg;
                    sneg_reg <= 1'b0;
                    rn_reg   <= '0;
                    rd_reg   <= WIDTH'(1);
                    p0_reg   <= '0;
                    p1_reg   <= WIDTH'(1);
                    q0_reg   <= WIDTH'(1);
                    q1_reg   <= '0;
                    // Mirrored interval swaps the ends
                    if (hi_neg)
                    begin
                        a_reg <= hi_mag; b_reg <= hi_den_w; c_reg <= lo_mag; d_reg <= lo_den_w;
                        oa_reg <= hi_mag; ob_reg <= hi_den_w;
                        oc_reg <= lo_mag; od_reg <= lo_den_w;
                    end
                    else
                    begin
                        a_reg <= lo_mag; b_reg <= lo_den_w; c_reg <= hi_mag; d_reg <= hi_den_w;
                        oa_reg <= lo_mag; ob_reg <= lo_den_w;
                        oc_reg <= hi_mag; od_reg <= hi_den_w;
                    end
                end
            end
            sfi_pkg::ST_CMP_DA, sfi_pkg::ST_SOL_DA:
            begin
                if (div_rsp.done)
                begin
                    qa_reg <= div_q;
                    ra_reg <= div_r;
                end
            end
            sfi_pkg::ST_CMP_EV:
            begin
                if (qa_ne || ra_z || rc_z)
                begin
                    err_reg <= qa_ne ? (qa_lt == sneg_reg) : (ra_z && rc_z ? 1'b0
                                                : (ra_z ? sneg_reg : !sneg_reg));
                    if (!(qa_ne ? (qa_lt == sneg_reg) : (ra_z && rc_z ? 1'b0
                                                : (ra_z ? sneg_reg : !sneg_reg))))
                    begin
                        a_reg <= oa_reg; b_reg <= ob_reg; c_reg <= oc_reg; d_reg <= od_reg;
                    end
                    else
                    begin
                        neg_reg <= 1'b0;
                    end
                end
                else
                begin
                    // Advance to the reciprocal remainders
                    a_reg <= b_reg; b_reg <= ra_reg; c_reg <= d_reg; d_reg <= div_r;
                    sneg_reg <= !sneg_reg;
                end
            end
            sfi_pkg::ST_SOL_EV:
            begin
                k_reg <= k_new;
                t_reg <= qa_reg;
                if (!(k_fits || rc_z || ra_z))
                begin
                    a_reg <= d_reg; b_reg <= div_r; c_reg <= b_reg; d_reg <= ra_reg;
                end
            end
            sfi_pkg::ST_MAC_P:
            begin
                if (mac_rsp.done)
                begin
                    p0_reg <= p1_reg;
                    p1_reg <= mac_res;
                end
            end
            sfi_pkg::ST_MAC_Q:
            begin
                if (mac_rsp.done)
                begin
                    q0_reg <= q1_reg;
                    q1_reg <= mac_res;
                end
            end
            sfi_pkg::ST_FIN_P:
            begin
                if (mac_rsp.done)
                    rn_reg <= mac_res;
            end
            sfi_pkg::ST_FIN_Q:
            begin
                if (mac_rsp.done)
                    rd_reg <= mac_res;
            end
            default:
            begin
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (deliver)
        begin
            if (err_reg)
            begin
                out_num_reg <= '0;
                out_den_reg <= (WIDTH-1)'(1);
            end
            else
            begin
                out_num_reg <= neg_reg ? WIDTH'(-rn_reg) : rn_reg;
                out_den_reg <= rd_reg[WIDTH-2:0];
            end
            out_err_reg <= err_reg;
        end
    end

    sfi_div #(.WIDTH(WIDTH)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .rsp       (div_rsp),
        .dividend  (div_n),
        .divisor   (div_d),
        .quotient  (div_q),
        .remainder (div_r)
    );

    sfi_mac #(.WIDTH(WIDTH)) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mac_req),
        .rsp    (mac_rsp),
        .mul_m  (mac_m),
        .mul_x  (mac_x),
        .add_y  (mac_y),
        .result (mac_res)
    );

    assign in_stall    = (state_reg != sfi_pkg::ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign result_num  = out_num_reg;
    assign result_den  = out_den_reg;
    assign input_error = out_err_reg;

`ifndef SYNTHESIS
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (result_den != '0))
        else $error("result denominator is zero");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && input_error) |-> (result_num == '0 && result_den == (WIDTH-1)'(1)))
        else $error("rejected request did not give 0/1");

    a_single_unit: assert property (@(posedge clk) disable iff (!rst_n)
        !(div_rsp.busy && mac_rsp.busy))
        else $error("divider and accumulator busy together");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("request accepted while sequencer not engaged");
`endif

endmodule

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives bound pairs into the simplest fraction unit under random idling on
// both sides and checks every answer against a typed answer or a continued-fraction predictor.
// ----------------------------------------------------------------------------

module testbench;

    localparam int W          = sfi_pkg::DEF_WIDTH;
    localparam int RAND_ITEMS = 400;
    localparam int HANG_LIMIT = 200000;
    localparam int DRAIN      = 400;

    typedef struct {
        logic signed [W-1:0] num;
        logic [W-2:0]        den;
        logic                err;
    } answer_t;

    typedef struct {
        logic signed [W-1:0] lnum;
        logic [W-2:0]        lden;
        logic signed [W-1:0] unum;
        logic [W-2:0]        uden;
        bit                  typed;
        answer_t             ans;
    } vector_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic signed [W-1:0] lower_num;
    logic [W-2:0]        lower_den;
    logic signed [W-1:0] upper_num;
    logic [W-2:0]        upper_den;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic signed [W-1:0] result_num;
    logic [W-2:0]        result_den;
    logic                input_error;

    answer_t pending_answers[$];
    int      mismatches = 0;
    int      send_idle_pct;
    int      recv_idle_pct;
    int      quiet_cycles = 0;
    bit      timed_out = 1'b0;

    simplest_fraction_in_interval_unit #(.WIDTH(W)) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .lower_num   (lower_num),
        .lower_den   (lower_den),
        .upper_num   (upper_num),
        .upper_den   (upper_den),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_num  (result_num),
        .result_den  (result_den),
        .input_error (input_error)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Order of a/b against c/d, all nonnegative, by quotient expansion
    function automatic int order_pos(longint unsigned a, longint unsigned b,
                                     longint unsigned c, longint unsigned d);
        int              s;
        longint unsigned qa, qc, ra, rc;
        s = 1;
        forever
        begin
            if (b == 0 || d == 0)
                return 0;
            qa = a / b;
            qc = c / d;
            if (qa != qc)
                return (qa < qc) ? -s : s;
            ra = a % b;
            rc = c % d;
            if (ra == 0 && rc == 0)
                return 0;
            if (ra == 0)
                return -s;
            if (rc == 0)
                return s;
            a = b; b = ra;
            c = d; d = rc;
            s = -s;
        end
    endfunction

    // Simplest fraction in [a/b, c/d] for 0 < a/b <= c/d
    function automatic void simplest_pos(longint unsigned a, longint unsigned b,
                                         longint unsigned c, longint unsigned d,
                                         output longint unsigned pn,
                                         output longint unsigned pd);
        longint unsigned p0, p1, q0, q1, k, t, nb, nd, np, nq;
        p0 = 0; p1 = 1; q0 = 1; q1 = 0;
        forever
        begin
            k = a / b + (((a % b) != 0) ? 1 : 0);
            t = c / d;
            if (k <= t)
                break;
            nb = c % d;
            nd = a % b;
            if (nb == 0 || nd == 0)
                break;
            t = k - 1;
            a = d; c = b; b = nb; d = nd;
            np = t * p1 + p0;
            nq = t * q1 + q0;
            p0 = p1; p1 = np;
            q0 = q1; q1 = nq;
        end
        pn = k * p1 + p0;
        pd = k * q1 + q0;
    endfunction

    function automatic answer_t predict_fraction(logic signed [W-1:0] ln,
                                                 logic [W-2:0] ld,
                                                 logic signed [W-1:0] un,
                                                 logic [W-2:0] ud);
        answer_t         r;
        longint          sl_v, su_v;
        longint unsigned lm, um, pn, pd;
        int              sl, su, ord;
        sl_v = ln;
        su_v = un;
        lm = (sl_v < 0) ? -sl_v : sl_v;
        um = (su_v < 0) ? -su_v : su_v;
        sl = (sl_v > 0) - (sl_v < 0);
        su = (su_v > 0) - (su_v < 0);
        r.num = '0;
        r.den = 1;
        r.err = 1'b0;
        pn = 0;
        pd = 1;
        if (ld == 0 || ud == 0)
            r.err = 1'b1;
        else
        begin
            if (sl != su)
                ord = (sl < su) ? -1 : 1;
            else if (sl == 0)
                ord = 0;
            else if (sl > 0)
                ord = order_pos(lm, ld, um, ud);
            else
                ord = order_pos(um, ud, lm, ld);
            r.err = (ord > 0);
        end
        if (!r.err)
        begin
            if (su < 0)
            begin
                simplest_pos(um, ud, lm, ld, pn, pd);
                r.num = -$signed(W'(pn));
                r.den = pd[W-2:0];
            end
            else if (sl > 0)
            begin
                simplest_pos(lm, ld, um, ud, pn, pd);
                r.num = W'(pn);
                r.den = pd[W-2:0];
            end
        end
        return r;
    endfunction

    // Offer one request, hold it until taken, then log its expected answer
    task automatic send_request(vector_t v);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        lower_num <= v.lnum;
        lower_den <= v.lden;
        upper_num <= v.unum;
        upper_den <= v.uden;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_answers.push_back(v.typed ? v.ans
                                  : predict_fraction(v.lnum, v.lden, v.unum, v.uden));
    endtask

    function automatic logic signed [W-1:0] rand_num();
        logic signed [W-1:0] n;
        n = W'($urandom);
        if (n == {1'b1, {(W-1){1'b0}}})
            n = n + 1;
        return n;
    endfunction

    // Build a random request: mostly well-ordered close bounds, some rejects
    function automatic vector_t random_request();
        vector_t         v;
        int              kind, sz;
        longint unsigned mask, a, b, c, d;
        logic signed [W-1:0] tmp_n;
        logic [W-2:0]        tmp_d;
        v.typed = 1'b0;
        v.ans   = '{default: '0};
        kind = $urandom_range(99);
        if (kind < 75)
        begin
            sz   = ($urandom_range(3) == 0) ? 31 : $urandom_range(2, 16);
            mask = (64'd1 << sz) - 1;
            a = {$urandom, $urandom} & mask;
            b = ({$urandom, $urandom} & mask) | 1;
            d = ({$urandom, $urandom} & mask) | 1;
            c = (a * d) / b + $urandom_range(0, 3);
            if (c > 64'h7fff_ffff)
                c = 64'h7fff_ffff;
            v.lnum = W'(a);
            v.lden = b[W-2:0];
            v.unum = W'(c);
            v.uden = d[W-2:0];
            if ($urandom_range(3) == 0)
            begin
                tmp_n  = v.lnum;
                tmp_d  = v.lden;
                v.lnum = -v.unum;
                v.lden = v.uden;
                v.unum = -tmp_n;
                v.uden = tmp_d;
            end
            if (kind < 8)
            begin
                tmp_n  = v.lnum;
                v.lnum = v.unum + 1;
                v.unum = tmp_n;
            end
        end
        else
        begin
            v.lnum = rand_num();
            v.unum = rand_num();
            v.lden = (W-1)'($urandom);
            v.uden = (W-1)'($urandom);
            if (kind > 94)
            begin
                if ($urandom_range(1))
                    v.lden = '0;
                else
                    v.uden = '0;
            end
        end
        return v;
    endfunction

    // Answer checker: compare each taken result against the oldest expectation
    always @(posedge clk)
    begin
        answer_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0d/%0d err=%0b",
                             result_num, result_den, input_error);
            end
            else
            begin
                e = pending_answers.pop_front();
                if (result_num !== e.num || result_den !== e.den
                    || input_error !== e.err)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d/%0d err=%0b, got %0d/%0d err=%0b",
                                 e.num, e.den, e.err, result_num, result_den,
                                 input_error);
                end
            end
        end
    end

    // Stall the result side at random
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    // Watchdog: end the run if nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= HANG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("[simplest_fraction_in_interval_unit] ERROR");
            $finish;
        end
    end

    initial
    begin
        vector_t directed[$];
        int      ok;
        in_valid      = 1'b0;
        lower_num     = '0;
        lower_den     = '0;
        upper_num     = '0;
        upper_den     = '0;
        send_idle_pct = 33;
        recv_idle_pct = 69;
        rst_n         = 1'b0;

        // Fixed rows: typed answers where obvious, the rest go to the predictor
        directed = '{
            '{32'sd1, 31'd0, 32'sd2, 31'd3, 1, '{32'sd0, 31'd1, 1'b1}},
            '{32'sd1, 31'd2, 32'sd2, 31'd0, 1, '{32'sd0, 31'd1, 1'b1}},
            '{32'sd0, 31'd0, 32'sd0, 31'd0, 1, '{32'sd0, 31'd1, 1'b1}},
            '{32'sd2, 31'd3, 32'sd1, 31'd2, 1, '{32'sd0, 31'd1, 1'b1}},
            '{32'sd1, 31'd1, -32'sd1, 31'd1, 1, '{32'sd0, 31'd1, 1'b1}},
            '{-32'sd1, 31'd2, 32'sd1, 31'd3, 1, '{32'sd0, 31'd1, 1'b0}},
            '{32'sd0, 31'd5, 32'sd0, 31'd7, 1, '{32'sd0, 31'd1, 1'b0}},
            '{-32'sd2147483647, 31'd1, 32'sd2147483647, 31'd1, 1,
              '{32'sd0, 31'd1, 1'b0}},
            '{32'sd2147483647, 31'd1, 32'sd2147483647, 31'd1, 1,
              '{32'sd2147483647, 31'd1, 1'b0}},
            '{-32'sd2147483647, 31'd1, -32'sd2147483647, 31'd1, 1,
              '{-32'sd2147483647, 31'd1, 1'b0}},
            '{32'sd1, 31'h7fffffff, 32'sd1, 31'h7fffffff, 1,
              '{32'sd1, 31'h7fffffff, 1'b0}},
            '{32'sd2, 31'd4, 32'sd2, 31'd4, 1, '{32'sd1, 31'd2, 1'b0}},
            '{-32'sd6, 31'd4, -32'sd6, 31'd4, 1, '{-32'sd3, 31'd2, 1'b0}},
            '{32'sd1, 31'd3, 32'sd1, 31'd2, 0, '{default: '0}},
            '{-32'sd1, 31'd2, -32'sd1, 31'd3, 0, '{default: '0}},
            '{32'sd2147483646, 31'h7fffffff, 32'sd2147483647, 31'h7fffffff, 0,
              '{default: '0}},
            '{32'sd1134903170, 31'd1836311903, 32'sd1134903171, 31'd1836311903,
              0, '{default: '0}},
            '{32'sd1, 31'h7fffffff, 32'sd2, 31'h7ffffffe, 0, '{default: '0}},
            '{32'sd2147483647, 31'h7ffffffe, 32'sd2147483647, 31'h7ffffffd, 0,
              '{default: '0}},
            '{-32'sd355, 31'd113, -32'sd22, 31'd7, 0, '{default: '0}}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_request(directed[i]);

        // Three idling phases over the random requests
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            if (i == RAND_ITEMS / 3)
            begin
                send_idle_pct = 69;
                recv_idle_pct = 33;
            end
            else if (i == 2 * RAND_ITEMS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_request(random_request());
        end
        in_valid <= 1'b0;

        // Drain outstanding answers, then settle
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        ok = (mismatches == 0);
        if (ok)
            $display("[simplest_fraction_in_interval_unit] OK");
        else
            $display("[simplest_fraction_in_interval_unit] ERROR");
        $finish;
    end

endmodule
